// ===== hw/rtl/first_fit_heap_allocator_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the first-fit heap allocator
// Checks that are sampled on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FFHA_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FFHA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/ffha_pkg.sv =====
// ----------------------------------------------------------------------------
// First-fit heap allocator package
// Field widths, request and status codes, the block table entry and the
// sequencer state type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ffha_pkg;

	localparam int ADDR_W = 20;
	localparam int SIZE_W = 21;
	localparam int TYPE_W = 2;
	localparam int STAT_W = 3;
	localparam int ALU_W = 23;
	localparam int TOTAL_W = 22;

	localparam int HDR_BYTES = 16;
	localparam int ADDR_SPAN = 1048576;
	localparam logic [SIZE_W-1:0] LIMIT_RESET = 21'd1048576;

	localparam logic [TYPE_W-1:0] REQ_ALLOC = 2'd0;
	localparam logic [TYPE_W-1:0] REQ_FREE = 2'd1;
	localparam logic [TYPE_W-1:0] REQ_RESIZE = 2'd2;

	localparam logic [STAT_W-1:0] ST_OK = 3'd0;
	localparam logic [STAT_W-1:0] ST_NULL = 3'd1;
	localparam logic [STAT_W-1:0] ST_NOHEAP = 3'd2;
	localparam logic [STAT_W-1:0] ST_FULL = 3'd3;
	localparam logic [STAT_W-1:0] ST_UNKNOWN = 3'd4;

	typedef struct packed {
		logic [ADDR_W-1:0] base;
		logic [ADDR_W-1:0] size;
		logic              free;
	} ent_t;

	typedef enum logic [6:0] {
		S_IDLE    = 7'b0000001,
		S_SCAN    = 7'b0000010,
		S_FIT_HIT = 7'b0000100,
		S_APPEND  = 7'b0001000,
		S_OLD_HIT = 7'b0010000,
		S_RELEASE = 7'b0100000,
		S_DONE    = 7'b1000000
	} state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/first_fit_heap_allocator.sv =====
// ----------------------------------------------------------------------------
// First-fit heap allocator
// Keeps an ordered table of heap blocks and serves allocate, free and resize
// requests with a first-fit search and a heap top that rises on append and falls when the top block is freed.
// ----------------------------------------------------------------------------
// One request is taken at a time. Allocate and free walk the block table one
// entry per cycle through the single read port of the table memory; a resize
// that has to move its block walks the table twice. A zero-size allocate or
// resize, a free of a null address or an unused request type is answered
// without a table walk. The result sits in an output register, so the next
// request is accepted while it waits. The block table needs no clearing after
// reset.
`timescale 1ns / 1ps
`default_nettype none
`include "first_fit_heap_allocator_assert.svh"

module first_fit_heap_allocator #(
	parameter int MAX_BLOCKS = 64,
	parameter int HEAP_BYTES = 1048576
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic [ffha_pkg::TYPE_W-1:0]  req_type,
	input  wire logic [ffha_pkg::SIZE_W-1:0]  req_size,
	input  wire logic [ffha_pkg::ADDR_W-1:0]  req_addr,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic [ffha_pkg::ADDR_W-1:0]       result_addr,
	output logic [ffha_pkg::SIZE_W-1:0]       copy_bytes,
	output logic [ffha_pkg::STAT_W-1:0]       status,
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [ffha_pkg::SIZE_W-1:0]  cfg_data
);

	localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
	localparam int CAP_INT = (HEAP_BYTES < ffha_pkg::ADDR_SPAN) ? HEAP_BYTES
		: ffha_pkg::ADDR_SPAN;
	localparam logic [ffha_pkg::SIZE_W-1:0] LIM_CAP = ffha_pkg::SIZE_W'(CAP_INT);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BLOCKS);

	ffha_pkg::state_t state_q, state_d;

	logic [CNT_W-1:0]            cnt_q, cnt_d;
	logic [ffha_pkg::SIZE_W-1:0] top_q, top_d;
	logic [ffha_pkg::SIZE_W-1:0] limit_q;
	logic                        out_valid_q;
	logic                        chk_vld_q, chk_vld_d;
	logic [CNT_W-1:0]            scan_idx_q, scan_idx_d;
	logic                        mode_fit_q, mode_fit_d;
	logic                        move_q, move_d;

	logic [ffha_pkg::TYPE_W-1:0]  type_q, type_d;
	logic [ffha_pkg::SIZE_W-1:0]  size_q, size_d;
	logic [ffha_pkg::ADDR_W-1:0]  addr_q, addr_d;
	logic [ffha_pkg::TOTAL_W-1:0] total_q, total_d;
	logic [ffha_pkg::ADDR_W-1:0]  res_q, res_d;
	logic [ffha_pkg::SIZE_W-1:0]  copy_q, copy_d;
	logic [ffha_pkg::STAT_W-1:0]  st_q, st_d;
	logic [IDX_W-1:0]             chk_idx_q, chk_idx_d;
	logic [IDX_W-1:0]             fit_idx_q, fit_idx_d;
	logic [IDX_W-1:0]             old_idx_q, old_idx_d;
	ffha_pkg::ent_t               fit_ent_q, fit_ent_d;
	ffha_pkg::ent_t               old_ent_q, old_ent_d;
	logic [ffha_pkg::ADDR_W-1:0]  result_addr_q;
	logic [ffha_pkg::SIZE_W-1:0]  copy_bytes_q;
	logic [ffha_pkg::STAT_W-1:0]  status_q;

	ffha_pkg::ent_t mem_q [MAX_BLOCKS];
	ffha_pkg::ent_t rd_data_q;
	logic           wr_en;
	logic [IDX_W-1:0] wr_idx;
	ffha_pkg::ent_t wr_data;

	logic [ffha_pkg::ALU_W-1:0] alu_a, alu_b, alu_c, alu_sum;
	logic                       alu_gt, alu_eq;

	logic [ffha_pkg::SIZE_W-1:0] lim_eff;
	logic [ffha_pkg::SIZE_W-1:0] top_hdr;
	logic                        in_acc, out_load, scan_more, scan_hit, old_is_top;

	assign in_stall    = (state_q != ffha_pkg::S_IDLE);
	assign in_acc      = in_valid && !in_stall;
	assign cfg_ready   = 1'b1;
	assign out_valid   = out_valid_q;
	assign result_addr = result_addr_q;
	assign copy_bytes  = copy_bytes_q;
	assign status      = status_q;
	assign out_load    = (state_q == ffha_pkg::S_DONE) && (!out_valid_q || !out_stall);

	assign lim_eff    = (limit_q < LIM_CAP) ? limit_q : LIM_CAP;
	assign top_hdr    = top_q + ffha_pkg::SIZE_W'(ffha_pkg::HDR_BYTES);
	assign scan_more  = (scan_idx_q < cnt_q);
	assign old_is_top = ((CNT_W'(old_idx_q) + CNT_W'(1)) == cnt_q);

	// The shared add and compare unit.
	always_comb begin
		alu_a = '0;
		alu_b = '0;
		alu_c = '0;
		case (state_q)
			ffha_pkg::S_SCAN: begin
				if (mode_fit_q) begin
					alu_a = ffha_pkg::ALU_W'(rd_data_q.size);
					alu_c = ffha_pkg::ALU_W'(size_q);
				end else begin
					alu_a = ffha_pkg::ALU_W'(rd_data_q.base);
					alu_b = ffha_pkg::ALU_W'(ffha_pkg::HDR_BYTES);
					alu_c = ffha_pkg::ALU_W'(addr_q);
				end
			end
			ffha_pkg::S_APPEND: begin
				alu_a = ffha_pkg::ALU_W'(top_q);
				alu_b = ffha_pkg::ALU_W'(total_q);
				alu_c = ffha_pkg::ALU_W'(lim_eff);
			end
			ffha_pkg::S_FIT_HIT: begin
				alu_a = ffha_pkg::ALU_W'(fit_ent_q.base);
				alu_b = ffha_pkg::ALU_W'(ffha_pkg::HDR_BYTES);
			end
			ffha_pkg::S_OLD_HIT: begin
				alu_a = ffha_pkg::ALU_W'(old_ent_q.size);
				alu_c = ffha_pkg::ALU_W'(size_q);
			end
			default: begin
				alu_a = '0;
			end
		endcase
	end

	assign alu_sum  = alu_a + alu_b;
	assign alu_gt   = (alu_sum > alu_c);
	assign alu_eq   = (alu_sum == alu_c);
	assign scan_hit = chk_vld_q && (mode_fit_q ? (rd_data_q.free && (alu_gt || alu_eq))
		: (!rd_data_q.free && alu_eq));

	always_comb begin
		state_d    = state_q;
		cnt_d      = cnt_q;
		top_d      = top_q;
		chk_vld_d  = chk_vld_q;
		scan_idx_d = scan_idx_q;
		mode_fit_d = mode_fit_q;
		move_d     = move_q;
		type_d     = type_q;
		size_d     = size_q;
		addr_d     = addr_q;
		total_d    = total_q;
		res_d      = res_q;
		copy_d     = copy_q;
		st_d       = st_q;
		chk_idx_d  = chk_idx_q;
		fit_idx_d  = fit_idx_q;
		old_idx_d  = old_idx_q;
		fit_ent_d  = fit_ent_q;
		old_ent_d  = old_ent_q;
		wr_en      = 1'b0;
		wr_idx     = fit_idx_q;
		wr_data    = fit_ent_q;

		case (state_q)
			ffha_pkg::S_IDLE: begin
				if (in_acc) begin
					type_d     = req_type;
					size_d     = req_size;
					addr_d     = req_addr;
					total_d    = ffha_pkg::TOTAL_W'(req_size) +
						ffha_pkg::TOTAL_W'(ffha_pkg::HDR_BYTES);
					res_d      = '0;
					copy_d     = '0;
					st_d       = ffha_pkg::ST_NULL;
					move_d     = 1'b0;
					scan_idx_d = '0;
					chk_vld_d  = 1'b0;
					state_d    = ffha_pkg::S_DONE;
					case (req_type)
						ffha_pkg::REQ_ALLOC: begin
							mode_fit_d = 1'b1;
							if (req_size != '0) begin
								state_d = ffha_pkg::S_SCAN;
							end
						end
						ffha_pkg::REQ_FREE: begin
							mode_fit_d = 1'b0;
							if (req_addr != '0) begin
								state_d = ffha_pkg::S_SCAN;
							end
						end
						ffha_pkg::REQ_RESIZE: begin
							mode_fit_d = (req_addr == '0) || (req_size == '0);
							if (req_size != '0) begin
								state_d = ffha_pkg::S_SCAN;
							end
						end
						default: begin
							mode_fit_d = 1'b0;
						end
					endcase
				end
			end
			ffha_pkg::S_SCAN: begin
				if (scan_hit) begin
					chk_vld_d = 1'b0;
					if (mode_fit_q) begin
						fit_idx_d = chk_idx_q;
						fit_ent_d = rd_data_q;
						state_d   = ffha_pkg::S_FIT_HIT;
					end else begin
						old_idx_d = chk_idx_q;
						old_ent_d = rd_data_q;
						state_d   = (type_q == ffha_pkg::REQ_FREE) ? ffha_pkg::S_RELEASE
							: ffha_pkg::S_OLD_HIT;
					end
				end else if (!scan_more && !chk_vld_q) begin
					if (mode_fit_q) begin
						state_d = ffha_pkg::S_APPEND;
					end else begin
						st_d    = ffha_pkg::ST_UNKNOWN;
						state_d = ffha_pkg::S_DONE;
					end
				end else begin
					chk_vld_d = scan_more;
					chk_idx_d = scan_idx_q[IDX_W-1:0];
					if (scan_more) begin
						scan_idx_d = scan_idx_q + CNT_W'(1);
					end
				end
			end
			ffha_pkg::S_OLD_HIT: begin
				if (alu_gt || alu_eq) begin
					res_d   = addr_q;
					st_d    = ffha_pkg::ST_OK;
					state_d = ffha_pkg::S_DONE;
				end else begin
					move_d     = 1'b1;
					mode_fit_d = 1'b1;
					scan_idx_d = '0;
					chk_vld_d  = 1'b0;
					state_d    = ffha_pkg::S_SCAN;
				end
			end
			ffha_pkg::S_FIT_HIT: begin
				wr_en        = 1'b1;
				wr_idx       = fit_idx_q;
				wr_data      = fit_ent_q;
				wr_data.free = 1'b0;
				res_d        = alu_sum[ffha_pkg::ADDR_W-1:0];
				st_d         = ffha_pkg::ST_OK;
				state_d      = move_q ? ffha_pkg::S_RELEASE : ffha_pkg::S_DONE;
			end
			ffha_pkg::S_APPEND: begin
				if (alu_gt) begin
					st_d    = ffha_pkg::ST_NOHEAP;
					state_d = ffha_pkg::S_DONE;
				end else if (cnt_q == CNT_MAX) begin
					st_d    = ffha_pkg::ST_FULL;
					state_d = ffha_pkg::S_DONE;
				end else begin
					wr_en        = 1'b1;
					wr_idx       = cnt_q[IDX_W-1:0];
					wr_data.base = top_q[ffha_pkg::ADDR_W-1:0];
					wr_data.size = size_q[ffha_pkg::ADDR_W-1:0];
					wr_data.free = 1'b0;
					cnt_d        = cnt_q + CNT_W'(1);
					top_d        = alu_sum[ffha_pkg::SIZE_W-1:0];
					res_d        = top_hdr[ffha_pkg::ADDR_W-1:0];
					st_d         = ffha_pkg::ST_OK;
					state_d      = move_q ? ffha_pkg::S_RELEASE : ffha_pkg::S_DONE;
				end
			end
			ffha_pkg::S_RELEASE: begin
				if (old_is_top) begin
					top_d = ffha_pkg::SIZE_W'(old_ent_q.base);
					cnt_d = cnt_q - CNT_W'(1);
				end else begin
					wr_en        = 1'b1;
					wr_idx       = old_idx_q;
					wr_data      = old_ent_q;
					wr_data.free = 1'b1;
				end
				if (move_q) begin
					copy_d = ffha_pkg::SIZE_W'(old_ent_q.size);
				end
				st_d    = ffha_pkg::ST_OK;
				state_d = ffha_pkg::S_DONE;
			end
			ffha_pkg::S_DONE: begin
				if (out_load) begin
					state_d = ffha_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = ffha_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ffha_pkg::S_IDLE;
			cnt_q       <= '0;
			top_q       <= '0;
			limit_q     <= ffha_pkg::LIMIT_RESET;
			out_valid_q <= 1'b0;
			chk_vld_q   <= 1'b0;
			scan_idx_q  <= '0;
			mode_fit_q  <= 1'b0;
			move_q      <= 1'b0;
		end else begin
			state_q    <= state_d;
			cnt_q      <= cnt_d;
			top_q      <= top_d;
			chk_vld_q  <= chk_vld_d;
			scan_idx_q <= scan_idx_d;
			mode_fit_q <= mode_fit_d;
			move_q     <= move_d;
			if (cfg_valid && cfg_ready) begin
				limit_q <= cfg_data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		type_q    <= type_d;
		size_q    <= size_d;
		addr_q    <= addr_d;
		total_q   <= total_d;
		res_q     <= res_d;
		copy_q    <= copy_d;
		st_q      <= st_d;
		chk_idx_q <= chk_idx_d;
		fit_idx_q <= fit_idx_d;
		old_idx_q <= old_idx_d;
		fit_ent_q <= fit_ent_d;
		old_ent_q <= old_ent_d;
		if (out_load) begin
			result_addr_q <= res_q;
			copy_bytes_q  <= copy_q;
			status_q      <= st_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_idx] <= wr_data;
		end
		rd_data_q <= mem_q[scan_idx_q[IDX_W-1:0]];
	end

	`FFHA_ASSERT_SAME(a_cnt_bound, 1'b1, cnt_q <= CNT_MAX, "block count above table depth")
	`FFHA_ASSERT_SAME(a_top_bound, 1'b1, top_q <= LIM_CAP, "heap top above address span")
	`FFHA_ASSERT_SAME(a_empty_heap, 1'b1, (cnt_q == '0) == (top_q == '0),
		"heap top and block count disagree on an empty heap")
	`FFHA_ASSERT_NEXT(a_busy_after_req, in_acc, state_q != ffha_pkg::S_IDLE,
		"request accepted but sequencer stayed idle")
	`FFHA_ASSERT_NEXT(a_result_loaded, out_load, out_valid_q && state_q == ffha_pkg::S_IDLE,
		"finished request did not reach the output register")

endmodule

`default_nettype wire
